>>> rtl/clt_pkg.sv
// types, constants and lexer step functions for the config text lexer
`default_nettype none
package clt_pkg;

	localparam int LineBits  = 20;
	localparam int ColBits   = 16;
	localparam int ValueBits = 32;
	localparam int MaxRes    = 4;

	localparam logic [LineBits-1:0]  LineMax = {LineBits{1'b1}};
	localparam logic [ColBits-1:0]   ColMax  = {ColBits{1'b1}};
	localparam logic [ValueBits-1:0] VCap    = {1'b1, {(ValueBits-1){1'b0}}};

	localparam logic [3:0] EV_CHAR      = 4'd0;
	localparam logic [3:0] EV_SYMBOL    = 4'd1;
	localparam logic [3:0] EV_STR_END   = 4'd2;
	localparam logic [3:0] EV_IDENT_END = 4'd3;
	localparam logic [3:0] EV_INT_END   = 4'd4;
	localparam logic [3:0] EV_DBL_END   = 4'd5;
	localparam logic [3:0] EV_EOF       = 4'd6;
	localparam logic [3:0] EV_EOF_TOK   = 4'd7;
	localparam logic [3:0] EV_ERROR     = 4'd8;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_ILLEGAL = 3'd1;
	localparam logic [2:0] ERR_COMMENT = 3'd2;
	localparam logic [2:0] ERR_ESCAPE  = 3'd3;
	localparam logic [2:0] ERR_INTEGER = 3'd4;

	localparam int F_SIGN   = 0;
	localparam int F_DIGIT  = 1;
	localparam int F_FROZEN = 2;

	typedef enum logic [3:0] {
		M_START, M_SLASH, M_CLINE, M_CLONG, M_CSTAR, M_IDENT, M_NUM, M_ZERO,
		M_HEX, M_STR, M_ESC, M_HALT
	} mode_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic [3:0]                  event_kind;
		logic [7:0]                  out_char;
		logic signed [ValueBits-1:0] int_result;
		logic [2:0]                  error_kind;
		logic [LineBits-1:0]         line_no;
		logic [ColBits-1:0]          col_no;
		logic                        last_result;
	} result_t;

	typedef struct packed {
		logic [2:0]           cnt;
		result_t [MaxRes-1:0] res;
	} bundle_t;

	typedef struct packed {
		mode_t                mode;
		logic                 quote;
		logic                 frac;
		logic [ValueBits-1:0] accum;
		logic [2:0]           flags;
		logic                 nonempty;
		logic [LineBits-1:0]  line;
		logic [ColBits-1:0]   col;
	} lex_st_t;

	typedef struct packed {
		lex_st_t    st;
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
		logic       again;
	} feed_out_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic result_t mk(input logic [3:0] k, input logic [7:0] ch,
			input logic [ValueBits-1:0] v, input logic [2:0] e,
			input logic [LineBits-1:0] ln, input logic [ColBits-1:0] cl);
		result_t r;
		r.event_kind  = k;
		r.out_char    = ch;
		r.int_result  = v;
		r.error_kind  = e;
		r.line_no     = ln;
		r.col_no      = cl;
		r.last_result = 1'b0;
		return r;
	endfunction

	// fresh token start; result lands in r0
	function automatic feed_out_t start_char(input lex_st_t s, input logic [7:0] c);
		feed_out_t o;
		o = '0;
		o.st = s;
		o.st.mode = M_START;
		if (is_space(c)) begin
		end else if (c == "/") begin
			o.st.mode = M_SLASH;
		end else if (c == "{" || c == "}" || c == "[" || c == "]" || c == ","
				|| c == ":" || c == "#") begin
			o.r0 = mk(EV_SYMBOL, c, '0, ERR_NONE, s.line, s.col);
			o.n = 2'd1;
		end else if (c == 8'h22 || c == 8'h27) begin
			o.st.mode = M_STR;
			o.st.quote = (c == 8'h27);
			o.st.nonempty = 1'b0;
		end else if (is_alpha(c) || c == "_") begin
			o.st.mode = M_IDENT;
			o.r0 = mk(EV_CHAR, c, '0, ERR_NONE, s.line, s.col);
			o.n = 2'd1;
		end else if (is_digit(c) || c == "+" || c == "-" || c == ".") begin
			o.r0 = mk(EV_CHAR, c, '0, ERR_NONE, s.line, s.col);
			o.n = 2'd1;
			o.st.accum = '0;
			o.st.flags = '0;
			o.st.frac = 1'b0;
			if (is_digit(c)) begin
				o.st.accum = ValueBits'(c - "0");
				o.st.flags[F_DIGIT] = 1'b1;
			end else if (c == "-") begin
				o.st.flags[F_SIGN] = 1'b1;
			end else if (c == ".") begin
				o.st.flags[F_FROZEN] = 1'b1;
			end
			o.st.mode = (c == "0") ? M_ZERO : M_NUM;
		end else begin
			o.r0 = mk(EV_ERROR, 8'd0, '0, ERR_ILLEGAL, s.line, s.col);
			o.n = 2'd1;
			o.st.mode = M_HALT;
		end
		return o;
	endfunction

	function automatic feed_out_t num_char(input lex_st_t s, input logic [7:0] c);
		feed_out_t            o;
		logic [ValueBits+3:0] t;
		logic [ValueBits-1:0] v;
		o = '0;
		o.st = s;
		t = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1) + (ValueBits+4)'(c - "0");
		if (is_digit(c) || c == "+" || c == "-" || c == "." || c == "e" || c == "d") begin
			if (c == "." || c == "e" || c == "d") o.st.frac = 1'b1;
			if (is_digit(c)) begin
				if (!s.flags[F_FROZEN]) begin
					o.st.accum = (t > {4'd0, VCap}) ? VCap : t[ValueBits-1:0];
					o.st.flags[F_DIGIT] = 1'b1;
				end
			end else begin
				o.st.flags[F_FROZEN] = 1'b1;
			end
			o.r0 = mk(EV_CHAR, (c == "d") ? 8'h65 : c, '0, ERR_NONE, s.line, s.col);
			o.n = 2'd1;
			o.st.mode = M_NUM;
		end else if (s.frac) begin
			o.r0 = mk(EV_DBL_END, 8'd0, '0, ERR_NONE, s.line, s.col);
			o.n = 2'd1;
			o.st.mode = M_START;
			o.again = 1'b1;
		end else if (s.flags[F_DIGIT]) begin
			v = s.accum;
			if (s.flags[F_SIGN]) v = '0 - v;
			else if (v > VCap - 1'b1) v = VCap - 1'b1;
			o.r0 = mk(EV_INT_END, 8'd0, v, ERR_NONE, s.line, s.col);
			o.n = 2'd1;
			o.st.mode = M_START;
			o.again = 1'b1;
		end else begin
			o.r0 = mk(EV_ERROR, 8'd0, '0, ERR_INTEGER, s.line, s.col);
			o.n = 2'd1;
			o.st.mode = M_HALT;
		end
		return o;
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] h;
		h = 5'h10;
		if (is_digit(c)) h = 5'(c - "0");
		else if (c >= "a" && c <= "f") h = 5'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") h = 5'(c - "A" + 8'd10);
		return h;
	endfunction

	// one byte through the lexer, at most two results
	function automatic feed_out_t feed(input lex_st_t s, input logic [7:0] c);
		feed_out_t  o;
		feed_out_t  sc;
		logic [4:0] h;
		logic [7:0] t;
		o = '0;
		o.st = s;
		h = hex_val(c);
		t = 8'd0;
		unique case (s.mode)
			M_HALT: begin
			end
			M_SLASH: begin
				if (c == "/") o.st.mode = M_CLINE;
				else if (c == "*") o.st.mode = M_CLONG;
				else begin
					o.r0 = mk(EV_ERROR, 8'd0, '0, ERR_COMMENT, s.line, s.col);
					o.n = 2'd1;
					o.st.mode = M_HALT;
				end
			end
			M_CLINE: if (c == 8'h0a) o.st.mode = M_START;
			M_CLONG: if (c == "*") o.st.mode = M_CSTAR;
			M_CSTAR: begin
				if (c == "/") o.st.mode = M_START;
				else if (c != "*") o.st.mode = M_CLONG;
			end
			M_IDENT: begin
				o.n = 2'd1;
				if (is_alpha(c) || is_digit(c) || c == "_") begin
					o.r0 = mk(EV_CHAR, c, '0, ERR_NONE, s.line, s.col);
				end else begin
					o.r0 = mk(EV_IDENT_END, 8'd0, '0, ERR_NONE, s.line, s.col);
					o.st.mode = M_START;
					o.again = 1'b1;
				end
			end
			M_ZERO, M_NUM: begin
				if (s.mode == M_ZERO && (c == "x" || c == "X")) begin
					o.r0 = mk(EV_CHAR, c, '0, ERR_NONE, s.line, s.col);
					o.n = 2'd1;
					o.st.accum = '0;
					o.st.mode = M_HEX;
				end else begin
					o = num_char(s, c);
				end
			end
			M_HEX: begin
				o.n = 2'd1;
				if (!h[4]) begin
					o.st.accum = {s.accum[ValueBits-5:0], h[3:0]};
					o.r0 = mk(EV_CHAR, c, '0, ERR_NONE, s.line, s.col);
				end else begin
					o.r0 = mk(EV_INT_END, 8'd0, s.accum, ERR_NONE, s.line, s.col);
					o.st.mode = M_START;
					o.again = 1'b1;
				end
			end
			M_STR: begin
				if (c == (s.quote ? 8'h27 : 8'h22)) begin
					o.r0 = mk(EV_STR_END, 8'd0, '0, ERR_NONE, s.line, s.col);
					o.n = 2'd1;
					o.st.mode = M_START;
				end else if (c == 8'h5c) begin
					o.st.mode = M_ESC;
				end else begin
					o.r0 = mk(EV_CHAR, c, '0, ERR_NONE, s.line, s.col);
					o.n = 2'd1;
					o.st.nonempty = 1'b1;
				end
			end
			M_ESC: begin
				case (c)
					8'h22, 8'h2f, 8'h5c: t = c;
					"b": t = 8'd8;
					"f": t = 8'd12;
					"n": t = 8'd10;
					"r": t = 8'd13;
					"t": t = 8'd9;
					default: t = 8'd0;
				endcase
				o.n = 2'd1;
				if (t == 8'd0) begin
					o.r0 = mk(EV_ERROR, 8'd0, '0, ERR_ESCAPE, s.line, s.col);
					o.st.mode = M_HALT;
				end else begin
					o.r0 = mk(EV_CHAR, t, '0, ERR_NONE, s.line, s.col);
					o.st.nonempty = 1'b1;
					o.st.mode = M_STR;
				end
			end
			default: o = start_char(s, c);
		endcase
		if (o.again) begin
			sc = start_char(o.st, c);
			o.st = sc.st;
			o.r1 = sc.r0;
			o.n = o.n + sc.n;
			o.again = 1'b0;
		end
		if (c == 8'h0a) begin
			if (s.line < LineMax) o.st.line = s.line + 1'b1;
			o.st.col = '0;
		end else if (s.col < ColMax) begin
			o.st.col = s.col + 1'b1;
		end
		return o;
	endfunction

	function automatic bundle_t add_res(input bundle_t b, input result_t r);
		bundle_t o;
		o = b;
		if (b.cnt < 3'(MaxRes)) begin
			o.res[b.cnt[1:0]] = r;
			o.cnt = b.cnt + 1'b1;
		end
		return o;
	endfunction

	function automatic bundle_t add_feed(input bundle_t b, input feed_out_t f);
		bundle_t o;
		o = b;
		if (f.n >= 2'd1) o = add_res(o, f.r0);
		if (f.n >= 2'd2) o = add_res(o, f.r1);
		return o;
	endfunction

	function automatic lex_st_t st_reset();
		lex_st_t s;
		s = '0;
		s.mode = M_START;
		s.line = LineBits'(1);
		return s;
	endfunction

endpackage
`default_nettype wire

>>> rtl/config_text_lexer_top.sv
// top level of the config text lexer
// Lexer for JSON-like config text, one byte per item. An item is taken every cycle
// while full is low; the lexer state updates in that same cycle, and the one to four
// results that a byte causes go as a bundle into a four-entry queue. The back end
// hands out one result per cycle while pop is high and empty is low, so the
// sustained rate is one item per cycle for bytes with at most one result and
// is set by the result port otherwise. Bytes that cause no result reach no queue.
`default_nettype none
module config_text_lexer_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire clt_pkg::item_t  item,
	output logic                 empty,
	input  wire logic            pop,
	output clt_pkg::result_t     result
);

	clt_pkg::bundle_t fb;
	clt_pkg::bundle_t qb;
	logic             fb_valid;
	logic             qavail;
	logic             qrd;
	logic             take;

	assign take = push && !full;

	clt_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .item(item),
		.bundle(fb), .bundle_valid(fb_valid)
	);

	clt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(fb_valid), .wdata(fb), .full(full),
		.rd(qrd), .rdata(qb), .avail(qavail)
	);

	clt_back u_back (
		.clk(clk), .arst_n(arst_n), .qdata(qb), .qavail(qavail), .qrd(qrd),
		.empty(empty), .pop(pop), .result(result)
	);

endmodule
`default_nettype wire

>>> rtl/clt_front.sv
// lexer front: takes one byte a cycle while take is high and builds the bundle of results it causes
`default_nettype none
module clt_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire clt_pkg::item_t  item,
	output clt_pkg::bundle_t     bundle,
	output logic                 bundle_valid
);

	clt_pkg::lex_st_t  st_q;
	clt_pkg::lex_st_t  st_d;
	clt_pkg::feed_out_t f1;
	clt_pkg::feed_out_t f2;
	clt_pkg::bundle_t  b;
	logic              in_tok;

	always_comb begin
		b  = '0;
		f1 = '0;
		f2 = '0;
		st_d = st_q;
		in_tok = 1'b0;
		if (st_q.mode != clt_pkg::M_HALT) begin
			f1 = clt_pkg::feed(st_q, item.char_in);
			b = clt_pkg::add_feed(b, f1);
			st_d = f1.st;
			// a final byte that is not whitespace gets a trailing newline
			if (item.last_char && st_d.mode != clt_pkg::M_HALT
					&& !clt_pkg::is_space(item.char_in)) begin
				f2 = clt_pkg::feed(st_d, 8'h0a);
				b = clt_pkg::add_feed(b, f2);
				st_d = f2.st;
			end
			if (item.last_char && st_d.mode != clt_pkg::M_HALT) begin
				in_tok = (st_d.mode == clt_pkg::M_STR || st_d.mode == clt_pkg::M_ESC)
					&& st_d.nonempty;
				b = clt_pkg::add_res(b, clt_pkg::mk(in_tok ? clt_pkg::EV_EOF_TOK
					: clt_pkg::EV_EOF, 8'd0, '0, clt_pkg::ERR_NONE, st_d.line, st_d.col));
			end
		end
		if (b.cnt != 3'd0) b.res[2'(b.cnt - 3'd1)].last_result = 1'b1;
		if (item.last_char) st_d = clt_pkg::st_reset();
	end

	assign bundle       = b;
	assign bundle_valid = take && (b.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clt_pkg::st_reset();
		end else if (take) begin
			st_q <= st_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/clt_queue.sv
// short bundle queue between lexer front and result back end
`default_nettype none
module clt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire clt_pkg::bundle_t wdata,
	output logic                  full,
	input  wire logic             rd,
	output clt_pkg::bundle_t      rdata,
	output logic                  avail
);

	localparam int Depth = 4;

	clt_pkg::bundle_t mem_q [Depth];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       do_rd;

	assign full  = (cnt_q == 3'(Depth));
	assign avail = (cnt_q != 3'd0);
	assign rdata = mem_q[rp_q];
	assign do_rd = rd && avail;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(wr) - 3'(do_rd);
		end
	end

endmodule
`default_nettype wire

>>> rtl/clt_back.sv
// result back end: hands out the results of one bundle at a time
`default_nettype none
module clt_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire clt_pkg::bundle_t qdata,
	input  wire logic             qavail,
	output logic                  qrd,
	output logic                  empty,
	input  wire logic             pop,
	output clt_pkg::result_t      result
);

	clt_pkg::bundle_t cur_q;
	logic [1:0]       idx_q;
	logic             valid_q;
	logic             done;

	assign empty  = !valid_q;
	assign result = cur_q.res[idx_q];
	assign done   = pop && valid_q && (3'(idx_q) + 3'd1 == cur_q.cnt);
	assign qrd    = qavail && (!valid_q || done);

	always_ff @(posedge clk) begin
		if (qrd) cur_q <= qdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (qrd) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule
`default_nettype wire
